/* sv/three_button_long_press_combo_assert.svh */
// Assertion macros shared by the three-button long-press detector RTL.
// Every macro samples on the given clock and is disabled while reset is low.
`ifndef THREE_BUTTON_LONG_PRESS_COMBO_ASSERT_SVH
`define THREE_BUTTON_LONG_PRESS_COMBO_ASSERT_SVH

// A property that must hold at every sampled clock edge outside reset.
`define TBLPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define TBLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tblpc_pkg.sv */
// Shared constants and types for the three-button long-press detector.
// No dependencies; all files but the assertion header import this package.
`default_nettype none

package tblpc_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int BTN_IDX_W   = 2;
  localparam int TIME_W      = 32;
  localparam int DEB_W       = 16;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;

  // Per-button machine codes.
  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PENDING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ON      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PRESSED = 2'd3;

  // Event kinds.
  localparam logic [KIND_W-1:0] EVT_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] EVT_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] EVT_PAIR   = 2'd2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd2;

  localparam logic [NUM_BUTTONS-1:0] RST_ENABLED_MASK = 3'd7;
  localparam logic [DEB_W-1:0]       RST_DEBOUNCE     = 16'd50;
  localparam logic [TIME_W-1:0]      RST_LONG_PRESS   = 32'd1000;

  // What one button machine reports to the event logic for the current beat.
  typedef struct packed {
    logic [MODE_W-1:0] mode_d;
    logic              hit;
  } btn_status_t;

endpackage

`default_nettype wire

/* sv/tblpc_if.sv */
// Valid/ready channel interfaces for samples and events of the detector.
// Depends on tblpc_pkg for field widths.
`default_nettype none

interface tblpc_in_if;
  import tblpc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] pressed_bits;
  logic [TIME_W-1:0]      now_ms;

  modport source (output valid, output pressed_bits, output now_ms, input ready);
  modport sink   (input valid, input pressed_bits, input now_ms, output ready);
endinterface

interface tblpc_out_if;
  import tblpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    event_kind;
  logic [BTN_IDX_W-1:0] first_button;
  logic [BTN_IDX_W-1:0] second_button;

  modport source (output valid, output event_kind, output first_button,
                  output second_button, input ready);
  modport sink   (input valid, input event_kind, input first_button,
                  input second_button, output ready);
endinterface

`default_nettype wire

/* sv/tblpc_button.sv */
// One debounced button machine with its press timestamp.
// Depends on tblpc_pkg.
`default_nettype none

module tblpc_button (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         advance_i,
  input  wire logic                         enable_i,
  input  wire logic                         pressed_i,
  input  wire logic [tblpc_pkg::TIME_W-1:0] now_i,
  input  wire logic [tblpc_pkg::DEB_W-1:0]  debounce_i,
  input  wire logic [tblpc_pkg::TIME_W-1:0] long_press_i,
  output tblpc_pkg::btn_status_t            status_o
);
  import tblpc_pkg::*;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [TIME_W-1:0] held;
  logic              past_debounce;
  logic              past_long;
  logic              hit;

  assign held          = now_i - stamp_q;
  assign past_debounce = held > {{(TIME_W-DEB_W){1'b0}}, debounce_i};
  assign past_long     = held > long_press_i;

  always_comb begin
    mode_d  = mode_q;
    stamp_d = stamp_q;
    hit     = 1'b0;
    if (!enable_i) begin
      mode_d  = MODE_OFF;
      stamp_d = '0;
    end else if (pressed_i) begin
      unique case (mode_q)
        MODE_OFF: begin
          mode_d  = MODE_PENDING;
          stamp_d = now_i;
        end
        MODE_PENDING: begin
          if (past_debounce) mode_d = MODE_ON;
        end
        MODE_ON: begin
          if (past_long) begin
            mode_d = MODE_PRESSED;
            hit    = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      unique case (mode_q)
        MODE_PENDING: begin
          if (past_debounce) begin
            mode_d  = MODE_OFF;
            stamp_d = '0;
          end
        end
        default: begin
          mode_d  = MODE_OFF;
          stamp_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      stamp_q <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      stamp_q <= stamp_d;
    end
  end

  assign status_o.mode_d = mode_d;
  assign status_o.hit    = hit;

endmodule

`default_nettype wire

/* sv/three_button_long_press_combo.sv */
// Top level of the three-button long-press and two-button combo detector.
// Depends on tblpc_pkg, the channel interfaces in tblpc_if and tblpc_button.
//
//   channel   dir  handshake          payload
//   in_bus    in   valid/ready        pressed_bits[2:0], now_ms[31:0]
//   out_bus   out  valid/ready        event_kind[1:0], first_button[1:0],
//                                     second_button[1:0]
//   cfg       in   cfg_we_i (no wait) cfg_index_i[1:0], cfg_wdata_i[31:0]
//
// One sample beat is accepted per cycle while the output is not stalled, and each
// produces exactly one event beat. A beat is latched in an input register, then the
// three button machines and the event choice run in one pass into the output
// register, from which the event beat is offered. The button state advances only
// as a beat moves into the output register, so a stalled output freezes the
// machines and in_bus.ready drops once both registers are full and the output beat
// is not taken. Reset clears the machines and loads the register defaults; no
// clearing pass is needed.
`default_nettype none

`include "three_button_long_press_combo_assert.svh"

module three_button_long_press_combo (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  tblpc_in_if.sink                               in_bus,
  tblpc_out_if.source                            out_bus,
  input  wire logic                              cfg_we_i,
  input  wire logic [tblpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tblpc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import tblpc_pkg::*;

  // Configuration registers.
  logic [NUM_BUTTONS-1:0] enabled_mask_q;
  logic [DEB_W-1:0]       debounce_q;
  logic [TIME_W-1:0]      long_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_mask_q <= RST_ENABLED_MASK;
      debounce_q     <= RST_DEBOUNCE;
      long_press_q   <= RST_LONG_PRESS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLED_MASK: enabled_mask_q <= cfg_wdata_i[NUM_BUTTONS-1:0];
        CFG_DEBOUNCE:     debounce_q     <= cfg_wdata_i[DEB_W-1:0];
        CFG_LONG_PRESS:   long_press_q   <= cfg_wdata_i[TIME_W-1:0];
        default: ;  // Writes to unused indexes are dropped.
      endcase
    end
  end

  // Input register and the handshake of the two stages.
  logic                   s1_valid_q;
  logic [NUM_BUTTONS-1:0] s1_bits_q;
  logic [TIME_W-1:0]      s1_now_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   in_fire;

  // The input stage moves on when the output register is empty or draining.
  assign advance      = s1_valid_q && (!out_valid_q || out_bus.ready);
  assign in_bus.ready = !s1_valid_q || advance;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_q <= in_bus.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bits_q <= in_bus.pressed_bits;
      s1_now_q  <= in_bus.now_ms;
    end
  end

  // The three button machines update side by side from the latched sample.
  btn_status_t status [NUM_BUTTONS];

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    tblpc_button u_button (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .advance_i    (advance),
      .enable_i     (enabled_mask_q[g]),
      .pressed_i    (s1_bits_q[g]),
      .now_i        (s1_now_q),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .status_o     (status[g])
    );
  end

  // Event choice. The highest button that reached long press wins; its
  // partner is the lowest other button that is on or pressed after this
  // sample. A partner that is only on suppresses the event.
  logic                 win_found;
  logic [BTN_IDX_W-1:0] win_idx;
  logic                 partner_found;
  logic                 partner_pressed;
  logic [BTN_IDX_W-1:0] partner_idx;
  logic [KIND_W-1:0]    kind_d;
  logic [BTN_IDX_W-1:0] first_d, second_d;

  always_comb begin
    win_found = 1'b0;
    win_idx   = '0;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      if (status[k].hit) begin
        win_found = 1'b1;
        win_idx   = BTN_IDX_W'(k);
      end
    end

    partner_found   = 1'b0;
    partner_pressed = 1'b0;
    partner_idx     = '0;
    for (int k = NUM_BUTTONS - 1; k >= 0; k--) begin
      if (BTN_IDX_W'(k) != win_idx &&
          (status[k].mode_d == MODE_ON || status[k].mode_d == MODE_PRESSED)) begin
        partner_found   = 1'b1;
        partner_pressed = (status[k].mode_d == MODE_PRESSED);
        partner_idx     = BTN_IDX_W'(k);
      end
    end

    kind_d   = EVT_NONE;
    first_d  = '0;
    second_d = '0;
    if (win_found) begin
      if (!partner_found) begin
        kind_d  = EVT_SINGLE;
        first_d = win_idx;
      end else if (partner_pressed) begin
        kind_d   = EVT_PAIR;
        first_d  = win_idx;
        second_d = partner_idx;
      end
    end
  end

  // Output register.
  logic [KIND_W-1:0]    kind_q;
  logic [BTN_IDX_W-1:0] first_q, second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q   <= kind_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign out_bus.valid         = out_valid_q;
  assign out_bus.event_kind    = kind_q;
  assign out_bus.first_button  = first_q;
  assign out_bus.second_button = second_q;

  // A latched sample that cannot move on must still be there next cycle.
  `TBLPC_ASSERT_NEXT(a_s1_held, clk_i, rst_ni, s1_valid_q && !advance, s1_valid_q,
                     "latched sample lost while stalled")
  // No event means both button fields are zero.
  `TBLPC_ASSERT(a_none_zero, clk_i, rst_ni,
                !out_valid_q || kind_q != EVT_NONE || (first_q == '0 && second_q == '0),
                "button fields set without an event")
  // A single press carries no partner.
  `TBLPC_ASSERT(a_single_no_partner, clk_i, rst_ni,
                !out_valid_q || kind_q != EVT_SINGLE || second_q == '0,
                "single press reports a partner")
  // A two-button event names two different buttons.
  `TBLPC_ASSERT(a_pair_distinct, clk_i, rst_ni,
                !out_valid_q || kind_q != EVT_PAIR || first_q != second_q,
                "two-button event names one button twice")

endmodule

`default_nettype wire

/* dv/three_button_long_press_combo_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for three_button_long_press_combo: directed sample table, then
// random button traffic under several register settings, checked against a local model.
// Depends on tblpc_pkg, the channel interfaces in tblpc_if and the RTL top level.

module three_button_long_press_combo_test;
  import tblpc_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int CYCLE_LIMIT      = 1_000_000;
  // Wait after the last expected result so that any stray event beat is seen.
  localparam int SETTLE_CYCLES    = 6;
  localparam int BACKPRESSURE_AT  = 600;
  localparam int BACKPRESSURE_LEN = 400;
  localparam logic [TIME_W-1:0] STEP_CAP = 32'h0010_0000;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BTN_IDX_W-1:0] first;
    logic [BTN_IDX_W-1:0] second;
  } combo_event_t;

  typedef struct {
    logic [NUM_BUTTONS-1:0] bits;
    logic [TIME_W-1:0]      now;
    bit                     typed;
    combo_event_t           want;
  } sample_row_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tblpc_in_if  in_bus ();
  tblpc_out_if out_bus ();

  three_button_long_press_combo u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Local copy of the button machines and the registers, advanced once per accepted
  // sample beat and updated on every register write.
  logic [MODE_W-1:0]      mode_q  [NUM_BUTTONS];
  logic [TIME_W-1:0]      stamp_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] mask_q;
  logic [DEB_W-1:0]       debounce_q;
  logic [TIME_W-1:0]      long_press_q;

  combo_event_t pending_events[$];
  sample_row_t  directed_rows[$];

  int mismatches      = 0;
  int events_checked  = 0;
  int cycles          = 0;
  int burst_left      = 0;
  int hold_left       = 0;
  int open_left       = 0;
  int ready_roll      = 0;
  bit long_hold_done  = 1'b0;

  // Advance every button machine by one sample and return the event it raises.
  // Elapsed times wrap at 32 bits and every threshold test is strictly greater.
  function automatic combo_event_t next_combo_event(input logic [NUM_BUTTONS-1:0] bits,
                                                    input logic [TIME_W-1:0] now);
    combo_event_t      ev;
    int                hit;
    int                partner;
    logic [TIME_W-1:0] held;
    ev      = '0;
    hit     = -1;
    partner = -1;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      held = now - stamp_q[b];
      if (!mask_q[b]) begin
        // A disabled button sits in off and never joins an event.
        mode_q[b]  = MODE_OFF;
        stamp_q[b] = '0;
      end else if (bits[b]) begin
        case (mode_q[b])
          MODE_OFF: begin
            mode_q[b]  = MODE_PENDING;
            stamp_q[b] = now;
          end
          MODE_PENDING: begin
            if (held > TIME_W'(debounce_q)) mode_q[b] = MODE_ON;
          end
          MODE_ON: begin
            if (held > long_press_q) begin
              mode_q[b] = MODE_PRESSED;
              hit       = b;
            end
          end
          default: ;
        endcase
      end else if (mode_q[b] == MODE_PENDING) begin
        // A release only counts once it has outlasted the debounce time.
        if (held > TIME_W'(debounce_q)) begin
          mode_q[b]  = MODE_OFF;
          stamp_q[b] = '0;
        end
      end else begin
        mode_q[b]  = MODE_OFF;
        stamp_q[b] = '0;
      end
    end
    // The highest index that reached long press wins; its partner is the lowest
    // other button in on or pressed after this sample.
    if (hit >= 0) begin
      for (int k = NUM_BUTTONS - 1; k >= 0; k--) begin
        if (k != hit && (mode_q[k] == MODE_ON || mode_q[k] == MODE_PRESSED)) partner = k;
      end
      if (partner < 0) begin
        ev.kind  = EVT_SINGLE;
        ev.first = BTN_IDX_W'(hit);
      end else if (mode_q[partner] == MODE_PRESSED) begin
        ev.kind   = EVT_PAIR;
        ev.first  = BTN_IDX_W'(hit);
        ev.second = BTN_IDX_W'(partner);
      end
    end
    return ev;
  endfunction

  // Mostly back-to-back beats, sometimes a short gap, rarely a long one, and now
  // and then a burst with no gaps at all.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [NUM_BUTTONS-1:0] bits, input logic [TIME_W-1:0] now,
                         input bit typed, input logic [KIND_W-1:0] kind,
                         input logic [BTN_IDX_W-1:0] first,
                         input logic [BTN_IDX_W-1:0] second);
    sample_row_t row;
    row.bits        = bits;
    row.now         = now;
    row.typed       = typed;
    row.want.kind   = kind;
    row.want.first  = first;
    row.want.second = second;
    directed_rows.push_back(row);
  endtask

  // Offer one sample beat, wait for it to be taken, then queue what it must produce.
  // Typed rows queue the hand-written result; the local model still advances.
  task automatic send_sample(input logic [NUM_BUTTONS-1:0] bits, input logic [TIME_W-1:0] now,
                             input bit typed, input combo_event_t typed_event);
    int           gap;
    combo_event_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.pressed_bits <= bits;
    in_bus.now_ms       <= now;
    do @(posedge clk_i); while (!in_bus.ready);
    predicted = next_combo_event(bits, now);
    pending_events.push_back(typed ? typed_event : predicted);
  endtask

  // Stop offering samples and wait until every queued result has come back.
  task automatic settle_outputs();
    in_bus.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (index)
      CFG_ENABLED_MASK: mask_q       = data[NUM_BUTTONS-1:0];
      CFG_DEBOUNCE:     debounce_q   = data[DEB_W-1:0];
      CFG_LONG_PRESS:   long_press_q = data[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(input logic [NUM_BUTTONS-1:0] mask, input logic [DEB_W-1:0] deb,
                             input logic [TIME_W-1:0] long_press);
    settle_outputs();
    write_register(CFG_ENABLED_MASK, CFG_DATA_W'(mask));
    write_register(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    write_register(CFG_LONG_PRESS, long_press);
    cfg_we_i <= 1'b0;
  endtask

  // Random button traffic. Most beats follow buttons that are held or released for
  // long stretches while time moves forward at a rate matched to the thresholds, so
  // presses get through debounce and on to long press. Some beats land exactly on a
  // threshold or one past it; the rest are bounces and wild jumps in time.
  task automatic run_random(input int count);
    int                     roll;
    int                     b;
    int unsigned            step_max;
    logic [TIME_W-1:0]      reach;
    logic [NUM_BUTTONS-1:0] levels;
    logic [TIME_W-1:0]      clock;
    reach    = TIME_W'(debounce_q) + ((long_press_q > STEP_CAP) ? STEP_CAP : long_press_q);
    step_max = reach / 12 + 1;
    levels   = '0;
    clock    = $urandom;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 7) begin
        clock = $urandom;
        send_sample(NUM_BUTTONS'($urandom_range(0, 7)), clock, 1'b0, '0);
      end else if (roll < 11) begin
        clock += $urandom_range(0, 5);
        send_sample(levels ^ NUM_BUTTONS'($urandom_range(1, 7)), clock, 1'b0, '0);
      end else if (roll < 18) begin
        b = $urandom_range(0, NUM_BUTTONS - 1);
        if (mode_q[b] == MODE_PENDING) begin
          clock = stamp_q[b] + TIME_W'(debounce_q) + $urandom_range(0, 1);
        end else if (mode_q[b] == MODE_ON) begin
          clock = stamp_q[b] + long_press_q + $urandom_range(0, 1);
        end else begin
          clock += $urandom_range(0, step_max);
        end
        send_sample(levels, clock, 1'b0, '0);
      end else begin
        for (int k = 0; k < NUM_BUTTONS; k++) begin
          if ($urandom_range(0, 19) == 0) levels[k] = ~levels[k];
        end
        clock += $urandom_range(0, step_max);
        send_sample(levels, clock, 1'b0, '0);
      end
    end
  endtask

  // Result checker: every accepted event beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_events
    combo_event_t got;
    combo_event_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.kind   = out_bus.event_kind;
      got.first  = out_bus.first_button;
      got.second = out_bus.second_button;
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: expected no event beat, got kind=%0d first=%0d second=%0d",
                 $time, got.kind, got.first, got.second);
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t: event mismatch expected kind=%0d first=%0d second=%0d,",
                   $time, want.kind, want.first, want.second,
                   " got kind=%0d first=%0d second=%0d",
                   got.kind, got.first, got.second);
        end
      end
    end
  end

  // Event receiver: mostly ready, with short and occasional long stalls, some open
  // stretches, and one long hold-off that fills the block and stalls its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (!long_hold_done && events_checked >= BACKPRESSURE_AT) begin
      long_hold_done = 1'b1;
      hold_left      = BACKPRESSURE_LEN;
      out_bus.ready <= 1'b0;
    end else if (open_left > 0) begin
      open_left--;
      out_bus.ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 4) begin
        open_left = $urandom_range(30, 80);
        out_bus.ready <= 1'b1;
      end else if (ready_roll < 70) begin
        out_bus.ready <= 1'b1;
      end else if (ready_roll < 97) begin
        hold_left = $urandom_range(0, 2);
        out_bus.ready <= 1'b0;
      end else begin
        hold_left = $urandom_range(10, 40);
        out_bus.ready <= 1'b0;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    in_bus.valid        = 1'b0;
    in_bus.pressed_bits = '0;
    in_bus.now_ms       = '0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = CFG_ENABLED_MASK;
    cfg_wdata_i         = '0;
    mask_q              = RST_ENABLED_MASK;
    debounce_q          = RST_DEBOUNCE;
    long_press_q        = RST_LONG_PRESS;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      mode_q[b]  = MODE_OFF;
      stamp_q[b] = '0;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset register values (debounce 50, long press 1000).
    // Idle sample straight after reset.
    add_row(3'b000, 32'd0, 1'b1, EVT_NONE, 2'd0, 2'd0);
    // Button 0 alone: press, debounce passes at 51 ms, long press at 1001 ms.
    add_row(3'b001, 32'd100, 1'b1, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b001, 32'd151, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b001, 32'd1101, 1'b1, EVT_SINGLE, 2'd0, 2'd0);
    add_row(3'b000, 32'd1200, 1'b0, EVT_NONE, 2'd0, 2'd0);
    // Buttons 0 and 1 reach long press together: the higher index reports the pair.
    add_row(3'b011, 32'd2000, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b011, 32'd2060, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b011, 32'd3001, 1'b1, EVT_PAIR, 2'd1, 2'd0);
    add_row(3'b000, 32'd3100, 1'b0, EVT_NONE, 2'd0, 2'd0);
    // Button 2 reaches long press while button 1 is only on: no event. Then button 1
    // gets there with button 2 already pressed.
    add_row(3'b100, 32'd4000, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b110, 32'd4100, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b110, 32'd4200, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b110, 32'd5001, 1'b1, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b110, 32'd5101, 1'b1, EVT_PAIR, 2'd1, 2'd2);
    add_row(3'b000, 32'd5200, 1'b0, EVT_NONE, 2'd0, 2'd0);
    // Bounce in pending: a short release keeps the stamp, a long one drops to off.
    add_row(3'b001, 32'd6000, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b000, 32'd6010, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b001, 32'd6020, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b000, 32'd6100, 1'b0, EVT_NONE, 2'd0, 2'd0);
    // All three buttons held across the wrap of the millisecond counter.
    add_row(3'b111, 32'hFFFF_FFF0, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b111, 32'h0000_0030, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b111, 32'h0000_03F0, 1'b0, EVT_NONE, 2'd0, 2'd0);
    add_row(3'b000, 32'hFFFF_FFFF, 1'b0, EVT_NONE, 2'd0, 2'd0);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].bits, directed_rows[i].now,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part across register settings, extremes included: zero thresholds,
    // the largest debounce, a long press that can never be reached, all buttons off.
    run_random(250);
    reconfigure(3'b111, 16'd0, 32'd0);
    run_random(150);
    reconfigure(3'b101, 16'hFFFF, 32'd5000);
    run_random(150);
    reconfigure(3'b010, 16'd10, 32'hFFFF_FFFF);
    run_random(100);
    reconfigure(3'b000, 16'd50, 32'd100);
    run_random(50);
    reconfigure(3'b110, 16'd1, 32'd1);
    run_random(150);
    reconfigure(3'b011, 16'd200, 32'd3000);
    run_random(200);
    reconfigure(3'b111, 16'd20, 32'd500);
    run_random(200);

    settle_outputs();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
